>>> hdl/vertex_transform_perspective_divide_top_macros.svh
// Assertion macros shared by the vertex transform block.
`ifndef VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_TOP_MACROS_SVH
`define VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VTPD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VTPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/vtpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vtpd_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CW            = 32;  // coordinate and coefficient width
  localparam int NUMW          = 66;  // dividend, remainder and divisor width
  localparam int QW            = 33;  // quotient bits resolved by the divider
  localparam int LANES         = 3;

  // Working set of the three divide lanes, which share one divisor.
  typedef struct packed {
    logic [LANES-1:0][NUMW-1:0] rem;
    logic [LANES-1:0][QW-1:0]   quo;
    logic [NUMW-1:0]            wm;
    logic [LANES-1:0]           neg;
    logic [LANES-1:0]           ovf;
    logic                       wz;
  } div_t;

  typedef struct packed {
    logic [LANES-1:0][CW-1:0] val;
    logic                     wz;
    logic                     sat;
  } res_t;

endpackage

`default_nettype wire

>>> hdl/vtpd_div.sv
`timescale 1ns / 1ps
`default_nettype none

module vtpd_div (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire vtpd_pkg::div_t din,
  output vtpd_pkg::div_t     dout
);
  import vtpd_pkg::*;

  div_t stg [QW];
  div_t nxt [QW];

  // One restoring step per stage, most significant quotient bit first.
  for (genvar s = 0; s < QW; s++) begin : g_step
    localparam int B = QW - 1 - s;
    div_t src;
    if (s == 0) begin : g_first
      assign src = din;
    end else begin : g_rest
      assign src = stg[s-1];
    end

    always_comb begin
      nxt[s] = src;
      for (int l = 0; l < LANES; l++) begin
        if ((src.rem[l] >> B) >= src.wm) begin
          nxt[s].rem[l]    = src.rem[l] - (src.wm << B);
          nxt[s].quo[l][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg[s] <= nxt[s];
      end
    end
  end

  assign dout = stg[QW-1];

endmodule

`default_nettype wire

>>> hdl/vertex_transform_perspective_divide_top.sv
// Channel | Direction | Handshake            | Payload
// input   | in        | in_valid / in_ready   | mode, coef_index, coef_value, x_in, y_in, z_in
// output  | out       | out_valid / out_ready | x_out, y_out, z_out, w_was_zero, saturated
//
// One beat is accepted per clock while the skid register is empty. A point passes through
// the multiply, two adder stages, sign and magnitude, overflow check,
// 33 restoring divider steps and the output register. A load beat only writes its coefficient.
// Synchronous reset clears all valid bits and restores the identity matrix.
// A skid register behind the output takes one more beat after the consumer stalls;
// the whole pipeline then holds until the skid drains.
`timescale 1ns / 1ps
`default_nettype none
`include "vertex_transform_perspective_divide_top_macros.svh"

module vertex_transform_perspective_divide_top #(
  parameter int FRAC_BITS = vtpd_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           mode,
  input  wire logic [3:0]                     coef_index,
  input  wire logic signed [vtpd_pkg::CW-1:0] coef_value,
  input  wire logic signed [vtpd_pkg::CW-1:0] x_in,
  input  wire logic signed [vtpd_pkg::CW-1:0] y_in,
  input  wire logic signed [vtpd_pkg::CW-1:0] z_in,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [vtpd_pkg::CW-1:0]      x_out,
  output logic signed [vtpd_pkg::CW-1:0]      y_out,
  output logic signed [vtpd_pkg::CW-1:0]      z_out,
  output logic                                w_was_zero,
  output logic                                saturated
);
  import vtpd_pkg::*;

  localparam int PW    = 2 * CW;            // product width
  localparam int SW    = PW + 2;            // full column sum width
  localparam int AW    = SW - FRAC_BITS;    // column sum after the fraction shift
  localparam int NPIPE = 5 + QW;            // stages that carry a valid bit
  localparam logic [CW-1:0] ONE_Q   = CW'(1) << FRAC_BITS;
  localparam logic [QW:0]   LIM_NEG = (QW+1)'(1) << (CW - 1);
  localparam logic [QW:0]   LIM_POS = LIM_NEG - (QW+1)'(1);
  localparam logic [CW-1:0] MIN_VAL = CW'(1) << (CW - 1);
  localparam logic [CW-1:0] MAX_VAL = MIN_VAL - CW'(1);

  logic en;
  logic [NPIPE-1:0] v;

  // Coefficient matrix, row times four plus column.
  logic signed [CW-1:0] coef [16];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 16; k++) begin
        coef[k] <= (k % 5 == 0) ? ONE_Q : '0;
      end
    end else if (in_valid && in_ready && !mode) begin
      coef[coef_index] <= coef_value;
    end
  end

  // The pipeline moves as a whole whenever the skid register is empty.
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NPIPE-2:0], in_valid && mode};
    end
  end

  // Stage 0: twelve products and the four constant terms scaled by one.
  logic signed [CW-1:0] pt [3];
  logic signed [PW-1:0] prod [4][4];

  assign pt[0] = x_in;
  assign pt[1] = y_in;
  assign pt[2] = z_in;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        for (int r = 0; r < 3; r++) begin
          prod[j][r] <= PW'(pt[r]) * PW'(coef[r*4 + j]);
        end
        prod[j][3] <= PW'(coef[12 + j]) <<< FRAC_BITS;
      end
    end
  end

  // Stage 1: pairwise sums.
  logic signed [PW:0] pair [4][2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        pair[j][0] <= (PW+1)'(prod[j][0]) + (PW+1)'(prod[j][1]);
        pair[j][1] <= (PW+1)'(prod[j][2]) + (PW+1)'(prod[j][3]);
      end
    end
  end

  // Stage 2: column sums, floored by dropping the fraction bits.
  logic signed [SW-1:0] full [4];
  logic signed [AW-1:0] acc [4];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      full[j] = SW'(pair[j][0]) + SW'(pair[j][1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        acc[j] <= full[j][SW-1:FRAC_BITS];
      end
    end
  end

  // Stage 3: magnitudes and signs. A zero w divides the undivided value by one.
  logic [AW-1:0] mag [4];
  div_t prep_next, prep, chk_next, chk, dres;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      mag[j] = acc[j][AW-1] ? (~acc[j] + AW'(1)) : acc[j];
    end
    prep_next    = '0;
    prep_next.wz = (acc[3] == '0);
    prep_next.wm = prep_next.wz ? NUMW'(1) : NUMW'(mag[3]);
    for (int l = 0; l < LANES; l++) begin
      prep_next.rem[l] = prep_next.wz ? NUMW'(mag[l]) : (NUMW'(mag[l]) << FRAC_BITS);
      prep_next.neg[l] = acc[l][AW-1] ^ (acc[3][AW-1] && !prep_next.wz);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep <= prep_next;
    end
  end

  // Stage 4: a quotient of 2^33 or more is flagged here and clamps later.
  always_comb begin
    chk_next = prep;
    for (int l = 0; l < LANES; l++) begin
      chk_next.ovf[l] = (prep.rem[l] >> QW) >= prep.wm;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chk <= chk_next;
    end
  end

  vtpd_div u_div (
    .clk  (clk),
    .en   (en),
    .din  (chk),
    .dout (dres)
  );

  // Clamp each quotient to the signed 32-bit range.
  res_t res_next, out_r, skid_r;
  logic skid_v;
  logic [QW:0] qmag [LANES];
  logic [LANES-1:0] lsat;

  always_comb begin
    res_next = '0;
    for (int l = 0; l < LANES; l++) begin
      qmag[l] = dres.ovf[l] ? '1 : {1'b0, dres.quo[l]};
      if (dres.neg[l]) begin
        lsat[l]         = qmag[l] > LIM_NEG;
        res_next.val[l] = lsat[l] ? MIN_VAL : (~qmag[l][CW-1:0] + CW'(1));
      end else begin
        lsat[l]         = qmag[l] > LIM_POS;
        res_next.val[l] = lsat[l] ? MAX_VAL : qmag[l][CW-1:0];
      end
    end
    res_next.wz  = dres.wz;
    res_next.sat = |lsat;
  end

  assign en = !skid_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_v) begin
        out_valid <= 1'b1;
        skid_v    <= 1'b0;
      end else begin
        out_valid <= v[NPIPE-1];
      end
    end else if (v[NPIPE-1]) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_r <= skid_v ? skid_r : res_next;
    end else if (en) begin
      skid_r <= res_next;
    end
  end

  assign x_out      = out_r.val[0];
  assign y_out      = out_r.val[1];
  assign z_out      = out_r.val[2];
  assign w_was_zero = out_r.wz;
  assign saturated  = out_r.sat;

  `VTPD_ASSERT_SAME(a_skid_behind_out, skid_v, out_valid, "skid holds a beat while output is empty")
  `VTPD_ASSERT_SAME(a_skid_stalls, skid_v, !in_ready, "input accepted while skid is full")
  `VTPD_ASSERT_NEXT(a_load_write, in_valid && in_ready && !mode, coef[$past(coef_index)] == $past(coef_value), "coefficient load not stored")
  `VTPD_ASSERT_NEXT(a_stall_holds, !en && v[NPIPE-1], v[NPIPE-1], "pipeline result lost during stall")

endmodule

`default_nettype wire

>>> dv/vertex_transform_perspective_divide_top_tb.sv
`timescale 1ns / 1ps

module vertex_transform_perspective_divide_top_tb;
  import vtpd_pkg::*;

  localparam int FRAC     = FRAC_BITS_DEF;
  localparam int N_RANDOM = 1230;
  localparam int N_DIR    = 21;
  // Cycles with no beat on either channel before the run is declared hung.
  localparam int STUCK_LIMIT = 5000;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_POINT = 1'b1;

  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
  localparam logic [31:0] MINV = 32'h8000_0000;

  typedef struct {
    logic [31:0] x, y, z;
    logic        wz, sat;
  } vertex_t;

  // One row of the directed table. Where has_exp is set, the expected vertex is
  // written out by hand; otherwise it comes from the predictor.
  typedef struct {
    logic        mode;
    logic [3:0]  idx;
    logic [31:0] val, x, y, z;
    logic        has_exp;
    logic [31:0] ex, ey, ez;
    logic        ewz, esat;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic mode = 1'b0;
  logic [3:0] coef_index = '0;
  logic signed [CW-1:0] coef_value = '0, x_in = '0, y_in = '0, z_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CW-1:0] x_out, y_out, z_out;
  logic w_was_zero, saturated;

  vertex_transform_perspective_divide_top dut (.*);

  always #4 clk = ~clk;

  // The predictor's own copy of the coefficient matrix, row*4 + column.
  logic signed [31:0] coef_mat [16];
  vertex_t pending_vertices [$];
  row_t    dir_rows [N_DIR];
  int      mismatches = 0;
  int      idle_cycles = 0;
  int      vertices_seen = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch on %s at vertex %0d: got %h, expected %h", what, vertices_seen, got,
             want);
    mismatches++;
  endtask

  function automatic logic [31:0] clamp32(input logic neg, input logic [127:0] mag,
                                          inout logic sat);
    if (neg) begin
      if (mag > 128'h8000_0000) begin
        sat = 1'b1;
        return MINV;
      end
      return 32'(-mag);
    end
    if (mag > 128'h7FFF_FFFF) begin
      sat = 1'b1;
      return MAXV;
    end
    return mag[31:0];
  endfunction

  // Row-vector transform with w = 1, floored to FRAC bits, then the divide by w.
  function automatic vertex_t transform_vertex(input logic signed [31:0] px, py, pz);
    logic signed [127:0] xs, ys, zs, sum;
    logic signed [127:0] acc [4];
    logic [127:0] wmag, amag;
    logic neg;
    vertex_t v;
    xs = px;
    ys = py;
    zs = pz;
    for (int j = 0; j < 4; j++) begin
      sum = xs * 128'(coef_mat[j]) + ys * 128'(coef_mat[4+j]) + zs * 128'(coef_mat[8+j])
          + (128'(coef_mat[12+j]) <<< FRAC);
      acc[j] = sum >>> FRAC;
    end
    v.sat = 1'b0;
    v.wz  = (acc[3] == 0);
    wmag  = acc[3] < 0 ? 128'(-acc[3]) : 128'(acc[3]);
    for (int j = 0; j < 3; j++) begin
      amag = acc[j] < 0 ? 128'(-acc[j]) : 128'(acc[j]);
      if (v.wz) begin
        neg = acc[j] < 0;
      end else begin
        amag = (amag << FRAC) / wmag;
        neg  = (acc[j] < 0) != (acc[3] < 0);
      end
      case (j)
        0: v.x = clamp32(neg, amag, v.sat);
        1: v.y = clamp32(neg, amag, v.sat);
        default: v.z = clamp32(neg, amag, v.sat);
      endcase
    end
    return v;
  endfunction

  // Mostly modest values near unity, some full-range words and some extremes.
  function automatic logic [31:0] pick_q();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 32'($urandom_range(0, 32'h60000)) - 32'h30000;
    if (r < 8) return $urandom;
    case ($urandom_range(0, 4))
      0: return MAXV;
      1: return MINV;
      2: return ONE;
      3: return 32'hFFFF_0000;
      default: return '0;
    endcase
  endfunction

  // Sends one beat after an optional gap. Valid is lowered only when a gap is
  // taken, so back-to-back beats never see valid dropped and raised in one step.
  task automatic send_beat(input logic m, input logic [3:0] idx,
                           input logic [31:0] val, px, py, pz,
                           input logic has_exp, input vertex_t typed, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    coef_index <= idx;
    coef_value <= val;
    x_in       <= px;
    y_in       <= py;
    z_in       <= pz;
    do @(posedge clk); while (!in_ready);
    // The beat is taken at this edge: update the matrix or queue the vertex.
    if (m == MODE_LOAD) coef_mat[idx] = val;
    else pending_vertices.push_back(has_exp ? typed : transform_vertex(px, py, pz));
  endtask

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    // Directed rows: identity, extremes, zero w, saturation, tiny and negative w.
    dir_rows[0]  = '{MODE_POINT, 4'd0, 0, ONE, 32'h2_0000, 32'h3_0000,
                     1, ONE, 32'h2_0000, 32'h3_0000, 0, 0};
    dir_rows[1]  = '{MODE_POINT, 4'd0, 0, MAXV, MINV, 0, 1, MAXV, MINV, 0, 0, 0};
    dir_rows[2]  = '{MODE_POINT, 4'd0, 0, 32'hFFFE_8000, 32'h8000, 32'hFFFF_FFFF,
                     1, 32'hFFFE_8000, 32'h8000, 32'hFFFF_FFFF, 0, 0};
    dir_rows[3]  = '{MODE_LOAD, 4'd15, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    dir_rows[4]  = '{MODE_POINT, 4'd0, 0, 32'h5_0000, 32'h6_0000, 32'h7_0000,
                     1, 32'h5_0000, 32'h6_0000, 32'h7_0000, 1, 0};
    dir_rows[5]  = '{MODE_POINT, 4'd0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0};
    dir_rows[6]  = '{MODE_LOAD, 4'd0, MAXV, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    dir_rows[7]  = '{MODE_POINT, 4'd0, 0, MAXV, 0, 0, 1, MAXV, 0, 0, 1, 1};
    dir_rows[8]  = '{MODE_LOAD, 4'd0, MINV, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    dir_rows[9]  = '{MODE_POINT, 4'd0, 0, MINV, 0, 0, 1, MAXV, 0, 0, 1, 1};
    dir_rows[10] = '{MODE_POINT, 4'd0, 0, MAXV, 0, 0, 1, MINV, 0, 0, 1, 1};
    dir_rows[11] = '{MODE_LOAD, 4'd0, ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    dir_rows[12] = '{MODE_LOAD, 4'd15, 32'h1, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    dir_rows[13] = '{MODE_POINT, 4'd0, 0, ONE, 0, 0, 1, MAXV, 0, 0, 0, 1};
    dir_rows[14] = '{MODE_LOAD, 4'd15, 32'hFFFF_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    dir_rows[15] = '{MODE_POINT, 4'd0, 0, ONE, 32'h2_0000, 32'h3_0000,
                     1, 32'hFFFF_0000, 32'hFFFE_0000, 32'hFFFD_0000, 0, 0};
    dir_rows[16] = '{MODE_LOAD, 4'd12, 32'h2_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    dir_rows[17] = '{MODE_LOAD, 4'd3, 32'h8000, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    dir_rows[18] = '{MODE_POINT, 4'd0, 0, 32'h3_0000, 32'hFFFF_8000, 32'h1234_5678,
                     0, 0, 0, 0, 0, 0};
    dir_rows[19] = '{MODE_LOAD, 4'd5, MINV, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    dir_rows[20] = '{MODE_POINT, 4'd0, 0, 32'hFFFF_FFFF, 32'h7654_3210, MINV,
                     0, 0, 0, 0, 0, 0};
  end

  // Stimulus: the directed table, then random beats with a pause to drain.
  initial begin
    vertex_t typed;
    logic [3:0] idx;
    logic [31:0] val;
    bit calm;
    for (int k = 0; k < 16; k++) coef_mat[k] = (k % 5 == 0) ? ONE : '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      typed = '{dir_rows[i].ex, dir_rows[i].ey, dir_rows[i].ez, dir_rows[i].ewz,
                dir_rows[i].esat};
      send_beat(dir_rows[i].mode, dir_rows[i].idx, dir_rows[i].val, dir_rows[i].x,
                dir_rows[i].y, dir_rows[i].z, dir_rows[i].has_exp, typed,
                $urandom_range(0, 2));
    end
    calm = 0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 150 == 0) calm = ($urandom_range(0, 3) == 0);
      // Halfway through, hold back until every vertex in flight has come out.
      if (i == N_RANDOM / 2) begin
        in_valid <= 1'b0;
        while (pending_vertices.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 4) == 0) begin
        idx = 4'($urandom_range(0, 15));
        // Zeros in the w column make zero-w vertices reasonably common.
        val = (idx[1:0] == 2'd3 && $urandom_range(0, 2) == 0) ? '0 : pick_q();
        send_beat(MODE_LOAD, idx, val, $urandom, $urandom, $urandom, 0, typed,
                  pick_gap(calm));
      end else begin
        send_beat(MODE_POINT, 4'($urandom_range(0, 15)), $urandom, pick_q(), pick_q(),
                  pick_q(), 0, typed, pick_gap(calm));
      end
    end
    in_valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // Result side: check each beat against the oldest expected vertex, then
  // decide the ready for the next cycle. Once, after 300 vertices, the
  // receiver holds ready low so the pipeline and skid fill up.
  initial begin
    vertex_t want;
    int stall_left;
    bit long_hold_done;
    bit calm;
    stall_left = 0;
    long_hold_done = 0;
    calm = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_vertices.size() == 0) begin
          report("unexpected vertex x_out", x_out, 32'h0);
        end else begin
          want = pending_vertices.pop_front();
          if (x_out !== want.x) report("x_out", x_out, want.x);
          if (y_out !== want.y) report("y_out", y_out, want.y);
          if (z_out !== want.z) report("z_out", z_out, want.z);
          if (w_was_zero !== want.wz) report("w_was_zero", 32'(w_was_zero), 32'(want.wz));
          if (saturated !== want.sat) report("saturated", 32'(saturated), 32'(want.sat));
        end
        vertices_seen++;
        if (vertices_seen % 120 == 0) calm = ($urandom_range(0, 3) == 0);
      end
      if (!long_hold_done && vertices_seen >= 300) begin
        long_hold_done = 1;
        stall_left = 150;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!calm) begin
          case ($urandom_range(0, 99)) inside
            [0:9]:   stall_left = $urandom_range(1, 3);
            [10:11]: stall_left = $urandom_range(10, 40);
            default: stall_left = 0;
          endcase
        end
      end
    end
  end

  // Watchdog: any beat on either channel resets the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STUCK_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule
